/* rtl/fmmp_pkg.sv */
// Package with the widths, state and job codes and a helper of the Fibonacci mod-m block.
package fmmp_pkg;

   localparam int INDEX_BITS = 50;
   localparam int MOD_BITS   = 32;

   // The reducer takes a sum of two products, padded to an even width, two bits a step.
   localparam int PROD_W    = 2 * MOD_BITS + 2;
   localparam int RED_STEPS = PROD_W / 2;
   localparam int STEP_W    = $clog2(RED_STEPS);
   localparam int CNT_W     = $clog2(INDEX_BITS);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_PREP  = 9'b000000010,
      ST_MUL   = 9'b000000100,
      ST_ADD   = 9'b000001000,
      ST_RED   = 9'b000010000,
      ST_STORE = 9'b000100000,
      ST_STEP  = 9'b001000000,
      ST_NEXT  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   // Which entry of the squared matrix is being formed.
   typedef logic [1:0] job_type;
   localparam job_type JOB_E0 = 2'd0;
   localparam job_type JOB_E1 = 2'd1;
   localparam job_type JOB_E3 = 2'd2;

   // Sum of two reduced values, reduced again.
   function automatic logic [MOD_BITS-1:0] mod_add(input logic [MOD_BITS-1:0] a,
                                                   input logic [MOD_BITS-1:0] b,
                                                   input logic [MOD_BITS-1:0] m);
      logic [MOD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[MOD_BITS-1:0];
   endfunction

endpackage

/* rtl/fibonacci_mod_matrix_power.sv */
// Top level: F(index) mod modulus by square-and-multiply on a symmetric 2x2 matrix.
//
//   channel   direction  ports                              meaning
//   request   in         req_valid/ready, index, modulus    Fibonacci index n, modulus m
//   response  out        rsp_valid/ready, value             F(n) mod m
//
// Every index bit costs three modular reductions of a two-product sum, each 33 steps
// on the shared two-bit-per-cycle reducer, fed by one 32x32 multiplier. A zero modulus
// gives a zero response in the cycle after acceptance. Synchronous reset returns to
// idle. req_ready is high only in idle, and a response holds until taken.
module fibonacci_mod_matrix_power (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fmmp_pkg::INDEX_BITS-1:0] req_index,
   input  logic [fmmp_pkg::MOD_BITS-1:0]   req_modulus,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fmmp_pkg::MOD_BITS-1:0]   rsp_value
);

   localparam int MB = fmmp_pkg::MOD_BITS;
   localparam int PW = fmmp_pkg::PROD_W;

   fmmp_pkg::state_type state_ff, state_in;

   logic [fmmp_pkg::INDEX_BITS-1:0] idx_ff, idx_in;
   logic [MB-1:0]   m_ff, m_in;
   logic [MB+1:0]   m3_ff, m3_in;
   logic [MB-1:0]   e0_ff, e0_in, e1_ff, e1_in, e3_ff, e3_in;
   logic [MB-1:0]   es_ff, es_in;
   logic [MB-1:0]   n0_ff, n0_in, n1_ff, n1_in;
   logic [2*MB-1:0] prod_ff, prod_in;
   logic [PW-1:0]   div_ff, div_in;
   logic [MB-1:0]   rem_ff, rem_in;
   logic [fmmp_pkg::STEP_W-1:0] step_ff, step_in;
   logic [fmmp_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   fmmp_pkg::job_type job_ff, job_in;
   logic            term_ff, term_in;
   logic [MB-1:0]   value_ff, value_in;

   logic [MB-1:0]   op_a, op_b;
   logic [MB+1:0]   red_t, red_m1, red_m2;
   logic [MB+1:0]   red_r;
   logic [MB-1:0]   one_mod;

   assign req_ready = (state_ff == fmmp_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == fmmp_pkg::ST_OUT);
   assign rsp_value = value_ff;

   assign one_mod = (req_modulus == MB'(1)) ? '0 : MB'(1);

   // Operand pairs of the squared symmetric matrix: e0^2+e1^2, e1*(e0+e3), e1^2+e3^2.
   always_comb begin
      case (job_ff)
         fmmp_pkg::JOB_E0: begin
            op_a = term_ff ? e1_ff : e0_ff;
            op_b = term_ff ? e1_ff : e0_ff;
         end
         fmmp_pkg::JOB_E1: begin
            op_a = term_ff ? '0 : e1_ff;
            op_b = term_ff ? '0 : es_ff;
         end
         fmmp_pkg::JOB_E3: begin
            op_a = term_ff ? e3_ff : e1_ff;
            op_b = term_ff ? e3_ff : e1_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // One radix-4 restoring step: the partial remainder stays below the modulus.
   always_comb begin
      red_t  = {rem_ff, div_ff[PW-1 -: 2]};
      red_m1 = {2'b00, m_ff};
      red_m2 = {1'b0, m_ff, 1'b0};
      if (red_t >= m3_ff) begin
         red_r = red_t - m3_ff;
      end else if (red_t >= red_m2) begin
         red_r = red_t - red_m2;
      end else if (red_t >= red_m1) begin
         red_r = red_t - red_m1;
      end else begin
         red_r = red_t;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      m_in     = m_ff;
      m3_in    = m3_ff;
      e0_in    = e0_ff;
      e1_in    = e1_ff;
      e3_in    = e3_ff;
      es_in    = es_ff;
      n0_in    = n0_ff;
      n1_in    = n1_ff;
      prod_in  = prod_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      job_in   = job_ff;
      term_in  = term_ff;
      value_in = value_ff;
      unique case (state_ff)
         fmmp_pkg::ST_IDLE: begin
            if (req_valid) begin
               idx_in = req_index;
               m_in   = req_modulus;
               m3_in  = {1'b0, req_modulus, 1'b0} + {2'b00, req_modulus};
               e0_in  = one_mod;
               e1_in  = '0;
               e3_in  = one_mod;
               cnt_in = fmmp_pkg::CNT_W'(fmmp_pkg::INDEX_BITS - 1);
               if (req_modulus == '0) begin
                  value_in = '0;
                  state_in = fmmp_pkg::ST_OUT;
               end else begin
                  state_in = fmmp_pkg::ST_PREP;
               end
            end
         end
         fmmp_pkg::ST_PREP: begin
            es_in    = fmmp_pkg::mod_add(e0_ff, e3_ff, m_ff);
            job_in   = fmmp_pkg::JOB_E0;
            term_in  = 1'b0;
            div_in   = '0;
            state_in = fmmp_pkg::ST_MUL;
         end
         fmmp_pkg::ST_MUL: begin
            prod_in  = op_a * op_b;
            state_in = fmmp_pkg::ST_ADD;
         end
         fmmp_pkg::ST_ADD: begin
            div_in = div_ff + PW'(prod_ff);
            if (!term_ff) begin
               term_in  = 1'b1;
               state_in = fmmp_pkg::ST_MUL;
            end else begin
               rem_in   = '0;
               step_in  = '0;
               state_in = fmmp_pkg::ST_RED;
            end
         end
         fmmp_pkg::ST_RED: begin
            rem_in  = red_r[MB-1:0];
            div_in  = {div_ff[PW-3:0], 2'b00};
            step_in = step_ff + fmmp_pkg::STEP_W'(1);
            if (step_ff == fmmp_pkg::STEP_W'(fmmp_pkg::RED_STEPS - 1)) begin
               state_in = fmmp_pkg::ST_STORE;
            end
         end
         fmmp_pkg::ST_STORE: begin
            term_in = 1'b0;
            div_in  = '0;
            case (job_ff)
               fmmp_pkg::JOB_E0: begin
                  n0_in    = rem_ff;
                  job_in   = fmmp_pkg::JOB_E1;
                  state_in = fmmp_pkg::ST_MUL;
               end
               fmmp_pkg::JOB_E1: begin
                  n1_in    = rem_ff;
                  job_in   = fmmp_pkg::JOB_E3;
                  state_in = fmmp_pkg::ST_MUL;
               end
               default: begin
                  e0_in    = n0_ff;
                  e1_in    = n1_ff;
                  e3_in    = rem_ff;
                  state_in = idx_ff[fmmp_pkg::INDEX_BITS-1] ? fmmp_pkg::ST_STEP
                                                            : fmmp_pkg::ST_NEXT;
               end
            endcase
         end
         fmmp_pkg::ST_STEP: begin
            // Multiplying by [[1,1],[1,0]] only shifts and adds the entries.
            e0_in    = fmmp_pkg::mod_add(e0_ff, e1_ff, m_ff);
            e1_in    = e0_ff;
            e3_in    = e1_ff;
            state_in = fmmp_pkg::ST_NEXT;
         end
         fmmp_pkg::ST_NEXT: begin
            idx_in = {idx_ff[fmmp_pkg::INDEX_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               value_in = e1_ff;
               state_in = fmmp_pkg::ST_OUT;
            end else begin
               cnt_in   = cnt_ff - fmmp_pkg::CNT_W'(1);
               state_in = fmmp_pkg::ST_PREP;
            end
         end
         fmmp_pkg::ST_OUT: begin
            if (rsp_ready) begin
               state_in = fmmp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fmmp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmmp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      m_ff     <= m_in;
      m3_ff    <= m3_in;
      e0_ff    <= e0_in;
      e1_ff    <= e1_in;
      e3_ff    <= e3_in;
      es_ff    <= es_in;
      n0_ff    <= n0_in;
      n1_ff    <= n1_in;
      prod_ff  <= prod_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      cnt_ff   <= cnt_in;
      job_ff   <= job_in;
      term_ff  <= term_in;
      value_ff <= value_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_zero_mod: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_modulus == '0) |=> (rsp_valid && rsp_value == '0))
      else $error("zero modulus did not give an immediate zero response");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fmmp_pkg::ST_RED) |=> (rem_ff < m_ff))
      else $error("reducer remainder reached the modulus");

   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && m_ff != '0) |-> (rsp_value < m_ff))
      else $error("response not reduced below the modulus");

endmodule
